>>> src/tcw_pkg.sv
// Shared constants, types and address helpers for the text console writer.
package tcw_pkg;

	// Screen geometry
	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = ROWS * COLUMNS;

	localparam int ADDR_W = $clog2(CELL_COUNT);
	localparam int COL_W  = $clog2(COLUMNS + 1);
	localparam int ROW_W  = $clog2(ROWS);

	// Port field widths
	localparam int CMD_W     = 2;
	localparam int CHAR_W    = 8;
	localparam int IDX_W     = 11;
	localparam int OUT_COL_W = 7;
	localparam int OUT_ROW_W = 5;
	localparam int ATTR_W    = 8;
	localparam int COLOR_W   = 4;
	localparam int CELL_W    = CHAR_W + ATTR_W;

	// Configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic REG_FG = 1'b0;
	localparam logic REG_BG = 1'b1;

	localparam logic [COLOR_W-1:0] RESET_FG = 4'd15;
	localparam logic [COLOR_W-1:0] RESET_BG = 4'd0;

	localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'd32;
	localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
	localparam logic [ATTR_W-1:0] RESET_ATTR   = {RESET_BG, RESET_FG};

	localparam logic [COL_W-1:0]  COL_LIMIT  = COL_W'(COLUMNS);
	localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
	localparam logic [ADDR_W-1:0] CELL_LAST  = ADDR_W'(CELL_COUNT - 1);
	localparam logic [ADDR_W-1:0] ROW_SPAN   = ADDR_W'(COLUMNS - 1);

	typedef enum logic [2:0] {
		OP_PUT,
		OP_NEWLINE,
		OP_CLEAR,
		OP_READ,
		OP_NOP
	} op_kind_t;

	typedef struct packed {
		op_kind_t            kind;
		logic [CHAR_W-1:0]   ch;
		logic [ADDR_W-1:0]   idx;
		logic [ATTR_W-1:0]   attr;
	} op_t;

	typedef struct packed {
		logic [OUT_COL_W-1:0] column;
		logic [OUT_ROW_W-1:0] line;
		logic [CHAR_W-1:0]    rchar;
		logic [ATTR_W-1:0]    rattr;
		logic                 scroll;
	} res_t;

	// Logical (row, col) to store address; rows rotate around top.
	function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] top,
			logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
		logic [ROW_W:0] phys;
		phys = (ROW_W+1)'(top) + (ROW_W+1)'(row);
		if (phys >= (ROW_W+1)'(ROWS))
			phys = phys - (ROW_W+1)'(ROWS);
		return ADDR_W'(phys[ROW_W-1:0]) * ADDR_W'(COLUMNS) + ADDR_W'(col);
	endfunction

	// Logical flat index to store address.
	function automatic logic [ADDR_W-1:0] flat_addr(logic [ROW_W-1:0] top,
			logic [ADDR_W-1:0] idx);
		logic [ADDR_W:0] sum;
		sum = (ADDR_W+1)'(idx) + (ADDR_W+1)'(ADDR_W'(top) * ADDR_W'(COLUMNS));
		if (sum >= (ADDR_W+1)'(CELL_COUNT))
			sum = sum - (ADDR_W+1)'(CELL_COUNT);
		return sum[ADDR_W-1:0];
	endfunction

	function automatic logic [OUT_COL_W-1:0] out_col(logic [COL_W-1:0] col);
		logic [COL_W+OUT_COL_W-1:0] ext;
		ext = {OUT_COL_W'(0), col};
		return ext[OUT_COL_W-1:0];
	endfunction

	function automatic logic [OUT_ROW_W-1:0] out_row(logic [ROW_W-1:0] row);
		logic [ROW_W+OUT_ROW_W-1:0] ext;
		ext = {OUT_ROW_W'(0), row};
		return ext[OUT_ROW_W-1:0];
	endfunction

endpackage

>>> src/tcw_front.sv
// Command intake: classifies each beat and holds it in a two-entry op queue.
module tcw_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [tcw_pkg::CMD_W-1:0]     command,
	input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
	input  logic [tcw_pkg::IDX_W-1:0]     cell_index,
	input  logic [tcw_pkg::COLOR_W-1:0]   fg,
	input  logic [tcw_pkg::COLOR_W-1:0]   bg,
	output logic                          op_valid,
	output tcw_pkg::op_t                  op,
	input  logic                          op_pop
);

	tcw_pkg::op_t     slot_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       count_q;
	tcw_pkg::op_t     new_op;
	logic             in_range;
	logic             do_push, do_pop;

	assign in_range = (tcw_pkg::IDX_W + tcw_pkg::ADDR_W)'(cell_index)
		< (tcw_pkg::IDX_W + tcw_pkg::ADDR_W)'(tcw_pkg::CELL_COUNT);

	always_comb begin
		new_op.ch   = char_code;
		new_op.idx  = tcw_pkg::ADDR_W'(cell_index);
		new_op.attr = {bg, fg};
		case (command)
			tcw_pkg::CMD_PUT: begin
				new_op.kind = (char_code == tcw_pkg::NEWLINE_CHAR) ?
					tcw_pkg::OP_NEWLINE : tcw_pkg::OP_PUT;
			end
			tcw_pkg::CMD_CLEAR: new_op.kind = tcw_pkg::OP_CLEAR;
			tcw_pkg::CMD_READ: begin
				new_op.kind = in_range ? tcw_pkg::OP_READ : tcw_pkg::OP_NOP;
			end
			default: new_op.kind = tcw_pkg::OP_NOP;
		endcase
	end

	assign full     = (count_q == 2'd2);
	assign op_valid = (count_q != 2'd0);
	assign op       = slot_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = op_pop && op_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= new_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push)
				wr_ptr_q <= !wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

>>> src/tcw_res_q.sv
// Two-entry result queue facing the pop side.
module tcw_res_q (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  tcw_pkg::res_t din,
	output logic          full,
	output logic          empty,
	input  logic          pop,
	output tcw_pkg::res_t dout
);

	tcw_pkg::res_t slot_q [2];
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    count_q;
	logic          do_wr, do_pop;

	assign full   = (count_q == 2'd2);
	assign empty  = (count_q == 2'd0);
	assign dout   = slot_q[rd_ptr_q];
	assign do_wr  = wr && !full;
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_wr)
			slot_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr)
				wr_ptr_q <= !wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, do_wr} - {1'b0, do_pop};
		end
	end

endmodule

>>> src/tcw_back.sv
// Execution engine: cursor, rotating screen store, blanking sweeps and reads.
module tcw_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          op_valid,
	input  tcw_pkg::op_t  op,
	output logic          op_pop,
	input  logic          res_full,
	output logic          res_wr,
	output tcw_pkg::res_t res
);

	typedef enum logic [4:0] {
		ST_INIT  = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_SWEEP = 5'b00100,
		ST_PUT   = 5'b01000,
		ST_READ  = 5'b10000
	} state_t;

	state_t                          state_q, state_d;
	logic [tcw_pkg::ROW_W-1:0]       top_q, top_d;
	logic [tcw_pkg::ROW_W-1:0]       row_q, row_d;
	logic [tcw_pkg::COL_W-1:0]       col_q, col_d;
	logic [tcw_pkg::ADDR_W-1:0]      sweep_q, sweep_d;
	logic [tcw_pkg::ADDR_W-1:0]      sweep_end_q, sweep_end_d;
	tcw_pkg::op_t                    cur_q, cur_d;

	logic [tcw_pkg::CELL_W-1:0]      mem [tcw_pkg::CELL_COUNT];
	logic [tcw_pkg::CELL_W-1:0]      rd_q;
	logic                            mem_we, mem_re;
	logic [tcw_pkg::ADDR_W-1:0]      mem_waddr, mem_raddr;
	logic [tcw_pkg::CELL_W-1:0]      mem_wdata;

	logic                            res_scroll, res_read;
	logic                            row_last, wrap;
	logic [tcw_pkg::ROW_W-1:0]       row_inc, top_inc;
	logic [tcw_pkg::ADDR_W-1:0]      top_base;

	assign row_last = (row_q == tcw_pkg::ROW_LAST);
	assign wrap     = (col_q >= tcw_pkg::COL_LIMIT);
	assign row_inc  = row_q + tcw_pkg::ROW_W'(1);
	assign top_inc  = (top_q == tcw_pkg::ROW_LAST) ? '0 : top_q + tcw_pkg::ROW_W'(1);
	assign top_base = tcw_pkg::ADDR_W'(top_q) * tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);

	always_comb begin
		state_d     = state_q;
		top_d       = top_q;
		row_d       = row_q;
		col_d       = col_q;
		sweep_d     = sweep_q;
		sweep_end_d = sweep_end_q;
		cur_d       = cur_q;
		op_pop      = 1'b0;
		mem_we      = 1'b0;
		mem_waddr   = '0;
		mem_wdata   = '0;
		mem_re      = 1'b0;
		mem_raddr   = '0;
		res_wr      = 1'b0;
		res_scroll  = 1'b0;
		res_read    = 1'b0;
		case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = sweep_q;
				mem_wdata = {tcw_pkg::RESET_ATTR, tcw_pkg::BLANK_CHAR};
				sweep_d   = sweep_q + tcw_pkg::ADDR_W'(1);
				if (sweep_q == tcw_pkg::CELL_LAST)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (op_valid && !res_full) begin
					op_pop = 1'b1;
					cur_d  = op;
					case (op.kind)
						tcw_pkg::OP_PUT: begin
							if (wrap && row_last) begin
								// scroll first, the character lands after the sweep
								top_d       = top_inc;
								col_d       = '0;
								sweep_d     = top_base;
								sweep_end_d = top_base + tcw_pkg::ROW_SPAN;
								state_d     = ST_SWEEP;
							end else if (wrap) begin
								row_d     = row_inc;
								col_d     = tcw_pkg::COL_W'(1);
								mem_we    = 1'b1;
								mem_waddr = tcw_pkg::cell_addr(top_q, row_inc, '0);
								mem_wdata = {op.attr, op.ch};
								res_wr    = 1'b1;
							end else begin
								col_d     = col_q + tcw_pkg::COL_W'(1);
								mem_we    = 1'b1;
								mem_waddr = tcw_pkg::cell_addr(top_q, row_q, col_q);
								mem_wdata = {op.attr, op.ch};
								res_wr    = 1'b1;
							end
						end
						tcw_pkg::OP_NEWLINE: begin
							col_d = '0;
							if (row_last) begin
								top_d       = top_inc;
								sweep_d     = top_base;
								sweep_end_d = top_base + tcw_pkg::ROW_SPAN;
								state_d     = ST_SWEEP;
							end else begin
								row_d  = row_inc;
								res_wr = 1'b1;
							end
						end
						tcw_pkg::OP_CLEAR: begin
							sweep_d     = '0;
							sweep_end_d = tcw_pkg::CELL_LAST;
							state_d     = ST_SWEEP;
						end
						tcw_pkg::OP_READ: begin
							mem_re    = 1'b1;
							mem_raddr = tcw_pkg::flat_addr(top_q, op.idx);
							state_d   = ST_READ;
						end
						default: res_wr = 1'b1;
					endcase
				end
			end
			ST_SWEEP: begin
				mem_we    = 1'b1;
				mem_waddr = sweep_q;
				mem_wdata = {cur_q.attr, tcw_pkg::BLANK_CHAR};
				sweep_d   = sweep_q + tcw_pkg::ADDR_W'(1);
				if (sweep_q == sweep_end_q) begin
					if (cur_q.kind == tcw_pkg::OP_PUT) begin
						state_d = ST_PUT;
					end else begin
						res_wr     = 1'b1;
						res_scroll = (cur_q.kind == tcw_pkg::OP_NEWLINE);
						state_d    = ST_IDLE;
					end
				end
			end
			ST_PUT: begin
				mem_we     = 1'b1;
				mem_waddr  = tcw_pkg::cell_addr(top_q, row_q, '0);
				mem_wdata  = {cur_q.attr, cur_q.ch};
				col_d      = tcw_pkg::COL_W'(1);
				res_wr     = 1'b1;
				res_scroll = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_READ: begin
				res_wr   = 1'b1;
				res_read = 1'b1;
				state_d  = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		res.column = tcw_pkg::out_col(col_d);
		res.line   = tcw_pkg::out_row(row_d);
		res.rchar  = res_read ? rd_q[tcw_pkg::CHAR_W-1:0] : '0;
		res.rattr  = res_read ? rd_q[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W] : '0;
		res.scroll = res_scroll;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rd_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk) begin
		cur_q       <= cur_d;
		sweep_end_q <= sweep_end_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			top_q   <= '0;
			row_q   <= '0;
			col_q   <= '0;
			sweep_q <= '0;
		end else begin
			state_q <= state_d;
			top_q   <= top_d;
			row_q   <= row_d;
			col_q   <= col_d;
			sweep_q <= sweep_d;
		end
	end

endmodule

>>> src/text_console_writer_core.sv
// Top level of the text console writer: APB color registers, front, back, result queue.
// Character-cell console over a 25x80 screen store of {attribute, character} cells.
// Commands are pushed as beats (push/full) and each gives exactly one result beat
// (empty/pop) carrying the cursor after the command, read data and a scroll flag.
// A two-entry command queue decouples intake from execution, so commands keep
// flowing in while the engine works. Work per command is set by the single
// write port of the screen store: a plain put or a newline without scroll
// writes at most one cell; a read uses a registered memory read; a newline on
// the last row blanks one row (rows rotate through a top-row pointer, so
// nothing is copied); a wrapping put on the last row blanks a row and then
// writes the character; clear blanks the whole store.
// After reset the store is blanked to space on white-on-black, one cell per
// cycle, over all 2000 cells; commands queue up but are not executed until that
// pass ends. Color registers (foreground at 0x0, background at 0x4) are written
// over APB; pready is tied high and reads return the register value.
module text_console_writer_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// command side
	input  logic                            push,
	output logic                            full,
	input  logic [tcw_pkg::CMD_W-1:0]       command,
	input  logic [tcw_pkg::CHAR_W-1:0]      char_code,
	input  logic [tcw_pkg::IDX_W-1:0]       cell_index,
	// result side
	output logic                            empty,
	input  logic                            pop,
	output logic [tcw_pkg::OUT_COL_W-1:0]   cursor_column,
	output logic [tcw_pkg::OUT_ROW_W-1:0]   cursor_line,
	output logic [tcw_pkg::CHAR_W-1:0]      read_char,
	output logic [tcw_pkg::ATTR_W-1:0]      read_attribute,
	output logic                            did_scroll,
	// configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tcw_pkg::PADDR_W-1:0]     paddr,
	input  logic [tcw_pkg::PDATA_W-1:0]     pwdata,
	output logic [tcw_pkg::PDATA_W-1:0]     prdata,
	output logic                            pready
);

	logic [tcw_pkg::COLOR_W-1:0] fg_q, bg_q;
	logic                        cfg_wr;
	logic                        op_valid, op_pop;
	tcw_pkg::op_t                op;
	logic                        res_full, res_wr;
	tcw_pkg::res_t               res_in, res_out;

	// APB: register select is the word address bit
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= tcw_pkg::RESET_FG;
			bg_q <= tcw_pkg::RESET_BG;
		end else if (cfg_wr) begin
			if (paddr[2] == tcw_pkg::REG_FG)
				fg_q <= pwdata[tcw_pkg::COLOR_W-1:0];
			if (paddr[2] == tcw_pkg::REG_BG)
				bg_q <= pwdata[tcw_pkg::COLOR_W-1:0];
		end
	end

	assign prdata = (paddr[2] == tcw_pkg::REG_BG) ?
		tcw_pkg::PDATA_W'(bg_q) : tcw_pkg::PDATA_W'(fg_q);

	// intake and classification; color captured with each command
	tcw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.command    (command),
		.char_code  (char_code),
		.cell_index (cell_index),
		.fg         (fg_q),
		.bg         (bg_q),
		.op_valid   (op_valid),
		.op         (op),
		.op_pop     (op_pop)
	);

	// execution; takes a command only when a result slot is free
	tcw_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op       (op),
		.op_pop   (op_pop),
		.res_full (res_full),
		.res_wr   (res_wr),
		.res      (res_in)
	);

	tcw_res_q u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_wr),
		.din    (res_in),
		.full   (res_full),
		.empty  (empty),
		.pop    (pop),
		.dout   (res_out)
	);

	assign cursor_column  = res_out.column;
	assign cursor_line    = res_out.line;
	assign read_char      = res_out.rchar;
	assign read_attribute = res_out.rattr;
	assign did_scroll     = res_out.scroll;

endmodule

>>> bench/text_console_writer_checker.sv
// Scoreboard for the text console writer: shadow screen, result compare, register readback.
module text_console_writer_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  logic                            full,
	input  logic [tcw_pkg::CMD_W-1:0]       command,
	input  logic [tcw_pkg::CHAR_W-1:0]      char_code,
	input  logic [tcw_pkg::IDX_W-1:0]       cell_index,
	input  logic                            empty,
	input  logic                            pop,
	input  logic [tcw_pkg::OUT_COL_W-1:0]   cursor_column,
	input  logic [tcw_pkg::OUT_ROW_W-1:0]   cursor_line,
	input  logic [tcw_pkg::CHAR_W-1:0]      read_char,
	input  logic [tcw_pkg::ATTR_W-1:0]      read_attribute,
	input  logic                            did_scroll,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tcw_pkg::PADDR_W-1:0]     paddr,
	input  logic [tcw_pkg::PDATA_W-1:0]     pwdata,
	input  logic [tcw_pkg::PDATA_W-1:0]     prdata,
	input  logic                            pready,
	output int                              errors,
	output int                              waiting
);
	timeunit 1ns;
	timeprecision 1ps;
	import tcw_pkg::*;

	// keep the log bounded on a badly broken build
	localparam int REPORT_CAP = 100;

	logic [CELL_W-1:0]    shadow_screen [CELL_COUNT];
	logic [OUT_COL_W-1:0] cur_col;
	logic [OUT_ROW_W-1:0] cur_row;
	logic [COLOR_W-1:0]   fg_reg;
	logic [COLOR_W-1:0]   bg_reg;
	res_t                 results_due [$];

	task automatic blank_cells(input int first, input int count);
		int i;
		for (i = first; i < first + count; i++)
			shadow_screen[i] = {bg_reg, fg_reg, BLANK_CHAR};
	endtask

	// column 0 of the next row; on the last row everything moves up one row
	task automatic feed_line(output logic scrolled);
		int i;
		cur_col  = '0;
		scrolled = 1'b0;
		if (cur_row < OUT_ROW_W'(ROWS - 1)) begin
			cur_row++;
		end else begin
			scrolled = 1'b1;
			for (i = 0; i < CELL_COUNT - COLUMNS; i++)
				shadow_screen[i] = shadow_screen[i + COLUMNS];
			blank_cells(CELL_COUNT - COLUMNS, COLUMNS);
		end
	endtask

	task automatic apply_console_command(input logic [CMD_W-1:0] cmd,
			input logic [CHAR_W-1:0] ch, input logic [IDX_W-1:0] idx, output res_t r);
		logic scrolled;
		scrolled = 1'b0;
		r = '0;
		case (cmd)
			CMD_PUT: begin
				if (ch == NEWLINE_CHAR) begin
					feed_line(scrolled);
				end else begin
					if (cur_col >= OUT_COL_W'(COLUMNS))
						feed_line(scrolled);
					shadow_screen[int'(cur_row) * COLUMNS + int'(cur_col)] = {bg_reg, fg_reg, ch};
					cur_col++;
				end
			end
			CMD_CLEAR: begin
				blank_cells(0, CELL_COUNT);
			end
			CMD_READ: begin
				if (idx < IDX_W'(CELL_COUNT)) begin
					r.rchar = shadow_screen[int'(idx)][CHAR_W-1:0];
					r.rattr = shadow_screen[int'(idx)][CELL_W-1:CHAR_W];
				end
			end
			default: ;
		endcase
		r.column = cur_col;
		r.line   = cur_row;
		r.scroll = scrolled;
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			errors++;
			if (errors <= REPORT_CAP)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			errors  = 0;
			fg_reg  = RESET_FG;
			bg_reg  = RESET_BG;
			cur_col = '0;
			cur_row = '0;
			blank_cells(0, CELL_COUNT);
			results_due.delete();
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == REG_FG)
						fg_reg = pwdata[COLOR_W-1:0];
					else
						bg_reg = pwdata[COLOR_W-1:0];
				end else begin
					check_field("prdata", 32'(paddr[2] == REG_FG ? fg_reg : bg_reg), prdata);
				end
			end
			if (push && !full) begin
				apply_console_command(command, char_code, cell_index, want);
				results_due.push_back(want);
			end
			if (pop && !empty) begin
				if (results_due.size() == 0) begin
					errors++;
					if (errors <= REPORT_CAP)
						$display("%0t: result beat with none expected, got column %0d line %0d",
							$time, cursor_column, cursor_line);
				end else begin
					want = results_due.pop_front();
					check_field("cursor_column", 32'(want.column), 32'(cursor_column));
					check_field("cursor_line", 32'(want.line), 32'(cursor_line));
					check_field("read_char", 32'(want.rchar), 32'(read_char));
					check_field("read_attribute", 32'(want.rattr), 32'(read_attribute));
					check_field("did_scroll", 32'(want.scroll), 32'(did_scroll));
				end
			end
		end
		waiting = results_due.size();
	end

endmodule

>>> bench/text_console_writer_core_tb.sv
// Testbench top for the text console writer: stimulus, pacing, watchdog and verdict.
module text_console_writer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tcw_pkg::*;

	localparam int RESET_CYCLES = 6;
	// worst legal quiet stretch is a full-screen clear (or the blanking pass
	// after reset) behind a stalled result port; take that several times over
	localparam int STALL_LIMIT  = 12000;
	// settle time after the last result; longer than a wrapping scroll
	localparam int DRAIN_CYCLES = 100;
	localparam int PHASES       = 8;
	localparam int RANDOM_ITEMS = 1630;

	// command code the block treats as a no-op
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef enum int {
		DRAIN_FREE,        // pop every cycle
		DRAIN_COIN,        // pop half the time
		DRAIN_RARE_STALL,  // mostly pop, odd single stalls
		DRAIN_BLOCKED      // long stalls with short windows
	} drain_mode_e;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic                 full;
	logic [CMD_W-1:0]     command = '0;
	logic [CHAR_W-1:0]    char_code = '0;
	logic [IDX_W-1:0]     cell_index = '0;
	logic                 empty;
	logic                 pop = 1'b0;
	logic [OUT_COL_W-1:0] cursor_column;
	logic [OUT_ROW_W-1:0] cursor_line;
	logic [CHAR_W-1:0]    read_char;
	logic [ATTR_W-1:0]    read_attribute;
	logic                 did_scroll;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [PADDR_W-1:0]   paddr = '0;
	logic [PDATA_W-1:0]   pwdata = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	int check_errors;
	int results_waiting;
	int quiet_cycles = 0;
	int burst_left = 0;

	always #1 clk = ~clk;

	text_console_writer_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.command        (command),
		.char_code      (char_code),
		.cell_index     (cell_index),
		.empty          (empty),
		.pop            (pop),
		.cursor_column  (cursor_column),
		.cursor_line    (cursor_line),
		.read_char      (read_char),
		.read_attribute (read_attribute),
		.did_scroll     (did_scroll),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	text_console_writer_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.command        (command),
		.char_code      (char_code),
		.cell_index     (cell_index),
		.empty          (empty),
		.pop            (pop),
		.cursor_column  (cursor_column),
		.cursor_line    (cursor_line),
		.read_char      (read_char),
		.read_attribute (read_attribute),
		.did_scroll     (did_scroll),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.errors         (check_errors),
		.waiting        (results_waiting)
	);

	// Watchdog: any beat on either channel or a register access counts as progress.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (psel && penable && pready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("** text_console_writer_core: FAILED **");
			$finish;
		end
	end

	// Result side: pop pattern switches mode after spans of random length, so stalls
	// land on every phase of the engine's work, with clean stretches in between.
	initial begin : result_pacing
		drain_mode_e mode;
		int span;
		int k;
		forever begin
			mode = drain_mode_e'($urandom_range(0, 3));
			span = $urandom_range(32, 300);
			for (k = 0; k < span; k++) begin
				@(negedge clk);
				case (mode)
					DRAIN_FREE:       pop <= 1'b1;
					DRAIN_COIN:       pop <= ($urandom_range(0, 1) == 1);
					DRAIN_RARE_STALL: pop <= ($urandom_range(0, 9) != 0);
					default:          pop <= ((k % 24) >= 18);
				endcase
			end
		end
	end

	// One command beat. Bursts of random length; a new burst may start with a
	// gap (push low) or run straight on from the previous one.
	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
			input logic [IDX_W-1:0] idx);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				@(negedge clk);
				push <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		push       <= 1'b1;
		command    <= cmd;
		char_code  <= ch;
		cell_index <= idx;
		do @(posedge clk); while (full);
	endtask

	// APB: setup phase, then access phase held until pready.
	task automatic reg_access(input logic wr, input logic sel, input logic [PDATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {sel, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Color change only with the engine idle: stop sending, let every result
	// drain, then write both registers (junk in the unused upper bits) and read
	// them back.
	task automatic set_colors(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
		@(negedge clk);
		push <= 1'b0;
		burst_left = 0;
		wait (results_waiting == 0);
		repeat (4) @(posedge clk);
		reg_access(1'b1, REG_FG, {28'($urandom), fg});
		reg_access(1'b1, REG_BG, {28'($urandom), bg});
		reg_access(1'b0, REG_FG, '0);
		reg_access(1'b0, REG_BG, '0);
	endtask

	// Random command. Text phases break lines often so the cursor reaches the
	// bottom and scrolls; long-line phases rarely break so lines wrap, including
	// wraps on the last row. Unused fields always carry noise.
	task automatic pick_item(input logic long_lines, output logic [CMD_W-1:0] cmd,
			output logic [CHAR_W-1:0] ch, output logic [IDX_W-1:0] idx);
		int roll;
		roll = $urandom_range(0, 999);
		ch   = CHAR_W'($urandom);
		idx  = IDX_W'($urandom);
		if (roll < (long_lines ? 8 : 15)) begin
			cmd = CMD_CLEAR;
		end else if (roll < 40) begin
			cmd = CMD_UNUSED;
		end else if (roll < 180) begin
			cmd = CMD_READ;
			// mostly in range, sometimes anywhere the field reaches
			if ($urandom_range(0, 7) != 0)
				idx = IDX_W'($urandom_range(0, CELL_COUNT - 1));
		end else begin
			cmd = CMD_PUT;
			if ($urandom_range(0, 99) < (long_lines ? 1 : 15))
				ch = NEWLINE_CHAR;
		end
	endtask

	initial begin : stimulus
		logic [CMD_W-1:0]  cmd;
		logic [CHAR_W-1:0] ch;
		logic [IDX_W-1:0]  idx;
		logic [COLOR_W-1:0] fg;
		logic [COLOR_W-1:0] bg;
		int p;
		int n;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: reset screen contents, read range edges, field extremes,
		// newline, unused command, clear with the cursor staying put.
		send_item(CMD_READ, 8'd0, 11'd0);
		send_item(CMD_READ, 8'd255, IDX_W'(CELL_COUNT - 1));
		send_item(CMD_READ, 8'd0, IDX_W'(CELL_COUNT));       // just out of range
		send_item(CMD_READ, 8'd0, 11'h7FF);                  // top of the field
		send_item(CMD_PUT, 8'd0, 11'd0);
		send_item(CMD_PUT, 8'd255, 11'h7FF);
		send_item(CMD_PUT, BLANK_CHAR, 11'd0);
		send_item(CMD_PUT, NEWLINE_CHAR, 11'd0);
		send_item(CMD_PUT, 8'h41, 11'd0);
		send_item(CMD_READ, 8'd0, 11'd0);
		send_item(CMD_READ, 8'd0, 11'd1);
		send_item(CMD_READ, 8'd0, 11'd2);
		send_item(CMD_READ, 8'd0, IDX_W'(COLUMNS));
		send_item(CMD_UNUSED, 8'd255, 11'h7FF);
		send_item(CMD_UNUSED, 8'd0, 11'd0);
		send_item(CMD_CLEAR, 8'd0, 11'd0);
		send_item(CMD_READ, 8'd0, 11'd0);

		// colors at opposite extremes, then written and blanked cells show them
		set_colors(4'd0, 4'd15);
		send_item(CMD_PUT, 8'h7E, 11'd0);
		send_item(CMD_READ, 8'd0, IDX_W'(COLUMNS + 1));
		send_item(CMD_CLEAR, 8'hFF, 11'd0);
		send_item(CMD_READ, 8'd0, 11'd0);
		send_item(CMD_READ, 8'd0, IDX_W'(CELL_COUNT - 1));

		// Random phases, each under its own color setting.
		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: begin fg = 4'd0;  bg = 4'd0;  end
				1: begin fg = 4'd15; bg = 4'd15; end
				2: begin fg = 4'd15; bg = 4'd0;  end
				3: begin fg = 4'd0;  bg = 4'd15; end
				default: begin
					fg = COLOR_W'($urandom);
					bg = COLOR_W'($urandom);
				end
			endcase
			set_colors(fg, bg);
			for (n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
				pick_item(p % 2 == 1, cmd, ch, idx);
				send_item(cmd, ch, idx);
			end
		end

		@(negedge clk);
		push <= 1'b0;
		wait (results_waiting == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (check_errors == 0) begin
			$display("** text_console_writer_core: PASSED **");
		end else begin
			$display("** text_console_writer_core: FAILED **");
		end
		$finish;
	end

endmodule

>>> files.f
src/tcw_pkg.sv
src/tcw_front.sv
src/tcw_res_q.sv
src/tcw_back.sv
src/text_console_writer_core.sv
bench/text_console_writer_checker.sv
bench/text_console_writer_core_tb.sv
